### hdl/aes_ctr_pkg.sv
// Shared types, constants and functions for the AES-128 counter-mode cipher.
// Holds the S-box, round constants and the round helpers; no dependencies.
package aes_ctr_pkg;

  localparam int unsigned NumRounds = 10;

  localparam logic [1:0] CfgKeyHigh   = 2'd0;
  localparam logic [1:0] CfgKeyLow    = 2'd1;
  localparam logic [1:0] CfgNonceHigh = 2'd2;
  localparam logic [1:0] CfgNonceLow  = 2'd3;

  typedef logic [127:0] blk_t;

  // Sideband that travels with each request down the chain of round cells.
  typedef struct packed {
    logic         vld;
    logic [127:0] data;
    logic [4:0]   nbytes;
  } side_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte i of a block, byte 0 in the top bits.
  function automatic logic [7:0] get_byte(input blk_t b, input int unsigned i);
    get_byte = b[127 - 8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes, ShiftRows and (unless last) MixColumns of one round.
  function automatic blk_t round_fn(input blk_t s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = t[i];
    end
    round_fn = o;
  endfunction

  // Next round key from the previous one.
  function automatic blk_t key_step(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

endpackage

### hdl/aes_ctr_cell.sv
// One AES round cell: round transform plus its own key schedule step.
// Depends on aes_ctr_pkg.
module aes_ctr_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [7:0]         rcon,
  input  logic               last,
  input  aes_ctr_pkg::blk_t  state_in,
  input  aes_ctr_pkg::blk_t  key_in,
  input  aes_ctr_pkg::side_t side_in,
  output aes_ctr_pkg::blk_t  state_out,
  output aes_ctr_pkg::blk_t  key_out,
  output aes_ctr_pkg::side_t side_out
);

  aes_ctr_pkg::blk_t  state_r, key_r;
  aes_ctr_pkg::side_t side_r;
  aes_ctr_pkg::blk_t  key_nxt;

  assign key_nxt = aes_ctr_pkg::key_step(key_in, rcon);

  // The round key travels with the request so key changes never mix blocks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (adv) begin
      side_r.vld <= side_in.vld;
    end
    if (adv) begin
      state_r       <= aes_ctr_pkg::round_fn(state_in, last) ^ key_nxt;
      key_r         <= key_nxt;
      side_r.data   <= side_in.data;
      side_r.nbytes <= side_in.nbytes;
    end
  end

  assign state_out = state_r;
  assign key_out   = key_r;
  assign side_out  = side_r;

endmodule

### hdl/aes128_ctr_stream_cipher.sv
// AES-128 counter-mode cipher: a chain of ten round cells, one stage each.
// Path from input request to result: entry stage, ten rounds, output register.
// Throughput: one 16-byte block per cycle; the whole chain advances together
// and halts only while the output register is full and stalled.
// Reset (synchronous, rst_n low) clears key, nonce and counter to zero.
// Depends on aes_ctr_pkg and aes_ctr_cell.
module aes128_ctr_stream_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  input  logic [4:0]  in_valid_bytes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  output logic [4:0]  out_result_bytes
);

  localparam int unsigned NR = aes_ctr_pkg::NumRounds;

  logic [63:0] key_high_r, key_low_r, nonce_high_r, nonce_low_r;
  logic [127:0] ctr_r;
  logic adv, take;

  aes_ctr_pkg::blk_t  st   [NR+1];
  aes_ctr_pkg::blk_t  ky   [NR+1];
  aes_ctr_pkg::side_t sd   [NR+1];
  aes_ctr_pkg::blk_t  st0_r, ky0_r;
  aes_ctr_pkg::side_t sd0_r;
  logic [4:0] nb;

  logic         ov_r;
  logic [127:0] res_r;
  logic [4:0]   rb_r;
  logic [127:0] mask, ks_x;

  assign adv      = !ov_r || !out_stall;
  assign in_stall = !adv;
  assign take     = in_valid && adv;
  assign nb       = (in_valid_bytes > 5'd16) ? 5'd16 : in_valid_bytes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r   <= '0;
      key_low_r    <= '0;
      nonce_high_r <= '0;
      nonce_low_r  <= '0;
      ctr_r        <= '0;
      sd0_r.vld    <= 1'b0;
    end else begin
      if (adv) begin
        sd0_r.vld <= in_valid;
      end
      if (cfg_we) begin
        case (cfg_index)
          aes_ctr_pkg::CfgKeyHigh:   key_high_r <= cfg_data;
          aes_ctr_pkg::CfgKeyLow:    key_low_r  <= cfg_data;
          aes_ctr_pkg::CfgNonceHigh: begin
            nonce_high_r <= cfg_data;
            ctr_r        <= {cfg_data, nonce_low_r};
          end
          aes_ctr_pkg::CfgNonceLow: begin
            nonce_low_r <= cfg_data;
            ctr_r       <= {nonce_high_r, cfg_data};
          end
          default: ;
        endcase
      end else if (take) begin
        ctr_r <= ctr_r + 128'd1;
      end
    end
    // Entry stage: initial AddRoundKey with the key as it stands now.
    if (adv) begin
      st0_r        <= ctr_r ^ {key_high_r, key_low_r};
      ky0_r        <= {key_high_r, key_low_r};
      sd0_r.data   <= {in_data_high, in_data_low};
      sd0_r.nbytes <= nb;
    end
  end

  assign st[0] = st0_r;
  assign ky[0] = ky0_r;
  assign sd[0] = sd0_r;

  for (genvar g = 0; g < NR; g++) begin : g_round
    aes_ctr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .rcon      (aes_ctr_pkg::RCON[g]),
      .last      (g == NR - 1),
      .state_in  (st[g]),
      .key_in    (ky[g]),
      .side_in   (sd[g]),
      .state_out (st[g+1]),
      .key_out   (ky[g+1]),
      .side_out  (sd[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask[127 - 8*i -: 8] = (i < sd[NR].nbytes) ? 8'hff : 8'h00;
    end
    ks_x = (st[NR] ^ sd[NR].data) & mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= sd[NR].vld;
    end
    if (adv) begin
      res_r <= ks_x;
      rb_r  <= sd[NR].nbytes;
    end
  end

  assign out_valid        = ov_r;
  assign out_result_high  = res_r[127:64];
  assign out_result_low   = res_r[63:0];
  assign out_result_bytes = rb_r;

endmodule
